FILE: hdl/nprb_pkg.sv
// Shared types and constants for the NAND page read block with bad-block skipping.
package nprb_pkg;

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_READY = 2'd1,
    FUNC_BYTE  = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    ACT_SELECT   = 3'd0,
    ACT_DESELECT = 3'd1,
    ACT_COMMAND  = 3'd2,
    ACT_ADDRESS  = 3'd3,
    ACT_STROBE   = 3'd4,
    ACT_DELIVER  = 3'd5,
    ACT_DONE     = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WAIT_READY,
    PH_WAIT_BYTE
  } phase_t;

  typedef enum logic [1:0] {
    TAIL_STROBE,
    TAIL_DONE,
    TAIL_SEQ
  } tail_t;

  typedef enum logic [3:0] {
    STEP_DELIVER,
    STEP_DESELECT,
    STEP_STROBE,
    STEP_DONE,
    STEP_SELECT,
    STEP_CMD_SETUP,
    STEP_COL_LO,
    STEP_COL_HI,
    STEP_PAGE_LO,
    STEP_PAGE_MID,
    STEP_PAGE_HI,
    STEP_CMD_CONFIRM
  } step_t;

  localparam logic [7:0] CMD_READ_SETUP   = 8'h00;
  localparam logic [7:0] CMD_READ_CONFIRM = 8'h30;
  localparam logic [7:0] MARKER_GOOD      = 8'hFF;

  typedef struct packed {
    logic [1:0]  func;
    logic [27:0] start_address;
    logic [28:0] length;
    logic [7:0]  flash_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  bus_byte;
    logic [27:0] buffer_index;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic        deliver;
    logic [7:0]  data;
    logic [27:0] index;
    logic        deselect;
    tail_t       tail;
    logic [15:0] col;
    logic [23:0] page;
  } job_t;

endpackage

FILE: hdl/nand_page_read_bad_block_skip_top.sv
// Top level of the NAND page read sequencer with bad-block skipping.
//
// The item channel takes start, flash-ready and data-byte items; the result
// channel gives bus actions (select, deselect, command, address, read strobe),
// delivered bytes with their buffer index, and done. The final result caused
// by an item carries last.
// Each accepted item is turned by the front end into at most one job in a
// four-entry queue; the sequencer drains that queue at one result per cycle
// while the receiver is ready. An item yields between zero and ten results,
// and the item channel keeps accepting one item per cycle until the queue
// is full. A data byte in mid-page therefore yields two results, and a page
// or block change up to ten.
// The job for an item is stored in the queue and then loaded into the sequencer before its first result appears.
// When the receiver stalls, the current result holds, the queue fills and
// then the item channel drops ready. Synchronous reset returns the read state
// to idle and empties the queue and the sequencer; no result is pending.
module nand_page_read_bad_block_skip_top import nprb_pkg::*; #(
  parameter int PAGE_BYTES      = 2048,
  parameter int PAGES_PER_BLOCK = 64,
  parameter int ADDRESS_BITS    = 28,
  parameter int QUEUE_DEPTH     = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  in_item_t  item,
  output logic      result_valid,
  input  logic      result_ready,
  output out_item_t result
);

  logic push_valid, push_ready, pop_valid, pop_ready;
  job_t push_job, pop_job;

  nprb_front #(
    .PAGE_BYTES      (PAGE_BYTES),
    .PAGES_PER_BLOCK (PAGES_PER_BLOCK),
    .ADDRESS_BITS    (ADDRESS_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push       (push_job)
  );

  nprb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push       (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop        (pop_job)
  );

  nprb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .job          (pop_job),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

FILE: hdl/nprb_front.sv
// Front end: accepts items, tracks the read state and issues at most one bus job per item.
module nprb_front import nprb_pkg::*; #(
  parameter int PAGE_BYTES      = 2048,
  parameter int PAGES_PER_BLOCK = 64,
  parameter int ADDRESS_BITS    = 28
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  output logic     item_ready,
  input  in_item_t item,
  output logic     push_valid,
  input  logic     push_ready,
  output job_t     push
);

  localparam int PB_LOG     = $clog2(PAGE_BYTES);
  localparam int BLK_LOG    = PB_LOG + $clog2(PAGES_PER_BLOCK);
  localparam int ALIGN_BITS = (BLK_LOG < ADDRESS_BITS) ? BLK_LOG : ADDRESS_BITS;
  localparam logic [ADDRESS_BITS-1:0] ADDR_ONE  = {{(ADDRESS_BITS-1){1'b0}}, 1'b1};
  localparam logic [ADDRESS_BITS-1:0] BLOCK_INC = ADDR_ONE << BLK_LOG;
  localparam logic [15:0] MARKER_COL = 16'(PAGE_BYTES);

  phase_t                  phase, phase_next;
  logic [ADDRESS_BITS-1:0] flash_address, flash_address_next;
  logic [28:0]             bytes_remaining, bytes_remaining_next;
  logic [27:0]             out_index, out_index_next;
  logic                    checking_marker, checking_marker_next;

  logic                    accept;
  logic [ADDRESS_BITS-1:0] start_addr, addr_inc, addr_skip;
  logic [28:0]             rem_dec;
  logic                    page_end;

  function automatic logic aligned(input logic [ADDRESS_BITS-1:0] a);
    return a[ALIGN_BITS-1:0] == '0;
  endfunction

  function automatic job_t seq_job(input logic [ADDRESS_BITS-1:0] a, input logic marker,
                                   input logic desel);
    job_t j;
    j          = '0;
    j.deselect = desel;
    j.tail     = TAIL_SEQ;
    j.col      = marker ? MARKER_COL : 16'(a[PB_LOG-1:0]);
    j.page     = 24'(a[ADDRESS_BITS-1:PB_LOG]);
    return j;
  endfunction

  assign accept     = item_valid & push_ready;
  assign item_ready = push_ready;
  assign start_addr = ADDRESS_BITS'(item.start_address);
  assign addr_inc   = flash_address + ADDR_ONE;
  assign addr_skip  = flash_address + BLOCK_INC;
  assign rem_dec    = bytes_remaining - 29'd1;
  assign page_end   = addr_inc[PB_LOG-1:0] == '0;

  always_comb begin
    phase_next = phase;
    case (item.func)
      FUNC_START: begin
        phase_next = (item.length == '0) ? PH_IDLE : PH_WAIT_READY;
      end
      FUNC_READY: begin
        if (phase == PH_WAIT_READY) begin
          phase_next = PH_WAIT_BYTE;
        end
      end
      FUNC_BYTE: begin
        if (phase == PH_WAIT_BYTE) begin
          if (checking_marker) begin
            phase_next = PH_WAIT_READY;
          end else if (rem_dec == '0) begin
            phase_next = PH_IDLE;
          end else if (page_end) begin
            phase_next = PH_WAIT_READY;
          end else begin
            phase_next = PH_WAIT_BYTE;
          end
        end
      end
      default: phase_next = phase;
    endcase
  end

  always_comb begin
    flash_address_next   = flash_address;
    bytes_remaining_next = bytes_remaining;
    out_index_next       = out_index;
    checking_marker_next = checking_marker;
    push_valid           = 1'b0;
    push                 = '0;
    case (item.func)
      FUNC_START: begin
        flash_address_next   = start_addr;
        bytes_remaining_next = item.length;
        out_index_next       = '0;
        checking_marker_next = 1'b0;
        push_valid           = item_valid;
        if (item.length == '0) begin
          push.tail = TAIL_DONE;
        end else begin
          checking_marker_next = aligned(start_addr);
          push                 = seq_job(start_addr, aligned(start_addr), 1'b0);
        end
      end
      FUNC_READY: begin
        if (phase == PH_WAIT_READY) begin
          push_valid = item_valid;
          push.tail  = TAIL_STROBE;
        end
      end
      FUNC_BYTE: begin
        if (phase == PH_WAIT_BYTE) begin
          push_valid = item_valid;
          if (checking_marker) begin
            if (item.flash_byte != MARKER_GOOD) begin
              flash_address_next   = addr_skip;
              checking_marker_next = aligned(addr_skip);
              push                 = seq_job(addr_skip, aligned(addr_skip), 1'b1);
            end else begin
              checking_marker_next = 1'b0;
              push                 = seq_job(flash_address, 1'b0, 1'b1);
            end
          end else begin
            out_index_next       = out_index + 28'd1;
            bytes_remaining_next = rem_dec;
            flash_address_next   = addr_inc;
            if (rem_dec == '0) begin
              push.deselect = 1'b1;
              push.tail     = TAIL_DONE;
            end else if (page_end) begin
              checking_marker_next = aligned(addr_inc);
              push                 = seq_job(addr_inc, aligned(addr_inc), 1'b1);
            end else begin
              push.tail = TAIL_STROBE;
            end
            push.deliver = 1'b1;
            push.data    = item.flash_byte;
            push.index   = out_index;
          end
        end
      end
      default: push_valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      flash_address   <= '0;
      bytes_remaining <= '0;
      out_index       <= '0;
      checking_marker <= 1'b0;
    end else if (accept) begin
      phase           <= phase_next;
      flash_address   <= flash_address_next;
      bytes_remaining <= bytes_remaining_next;
      out_index       <= out_index_next;
      checking_marker <= checking_marker_next;
    end
  end

endmodule

FILE: hdl/nprb_queue.sv
// Short job queue between the front end and the bus sequencer.
module nprb_queue import nprb_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop        = slots[rd_ptr];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push;
    end
  end

endmodule

FILE: hdl/nprb_back.sv
// Bus sequencer: expands each job into its result items, one item per cycle while the receiver is ready.
module nprb_back import nprb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      pop_valid,
  output logic      pop_ready,
  input  job_t      job,
  output logic      result_valid,
  input  logic      result_ready,
  output out_item_t result
);

  job_t  cur;
  logic  busy;
  step_t step, step_next;
  logic  is_last, fire, load;

  function automatic step_t tail_first(input tail_t t);
    case (t)
      TAIL_STROBE: return STEP_STROBE;
      TAIL_DONE:   return STEP_DONE;
      default:     return STEP_SELECT;
    endcase
  endfunction

  function automatic step_t first_step(input job_t j);
    if (j.deliver) begin
      return STEP_DELIVER;
    end else if (j.deselect) begin
      return STEP_DESELECT;
    end
    return tail_first(j.tail);
  endfunction

  assign is_last      = (step == STEP_STROBE) || (step == STEP_DONE) ||
                        (step == STEP_CMD_CONFIRM);
  assign fire         = busy & result_ready;
  assign load         = !busy || (fire && is_last);
  assign pop_ready    = load;
  assign result_valid = busy;

  always_comb begin
    case (step)
      STEP_DELIVER:   step_next = cur.deselect ? STEP_DESELECT : tail_first(cur.tail);
      STEP_DESELECT:  step_next = tail_first(cur.tail);
      STEP_SELECT:    step_next = STEP_CMD_SETUP;
      STEP_CMD_SETUP: step_next = STEP_COL_LO;
      STEP_COL_LO:    step_next = STEP_COL_HI;
      STEP_COL_HI:    step_next = STEP_PAGE_LO;
      STEP_PAGE_LO:   step_next = STEP_PAGE_MID;
      STEP_PAGE_MID:  step_next = STEP_PAGE_HI;
      STEP_PAGE_HI:   step_next = STEP_CMD_CONFIRM;
      default:        step_next = step;
    endcase
  end

  always_comb begin
    result.buffer_index = '0;
    result.last         = is_last;
    case (step)
      STEP_DELIVER: begin
        result.action       = ACT_DELIVER;
        result.bus_byte     = cur.data;
        result.buffer_index = cur.index;
      end
      STEP_DESELECT: begin
        result.action   = ACT_DESELECT;
        result.bus_byte = '0;
      end
      STEP_STROBE: begin
        result.action   = ACT_STROBE;
        result.bus_byte = '0;
      end
      STEP_DONE: begin
        result.action   = ACT_DONE;
        result.bus_byte = '0;
      end
      STEP_SELECT: begin
        result.action   = ACT_SELECT;
        result.bus_byte = '0;
      end
      STEP_CMD_SETUP: begin
        result.action   = ACT_COMMAND;
        result.bus_byte = CMD_READ_SETUP;
      end
      STEP_COL_LO: begin
        result.action   = ACT_ADDRESS;
        result.bus_byte = cur.col[7:0];
      end
      STEP_COL_HI: begin
        result.action   = ACT_ADDRESS;
        result.bus_byte = cur.col[15:8];
      end
      STEP_PAGE_LO: begin
        result.action   = ACT_ADDRESS;
        result.bus_byte = cur.page[7:0];
      end
      STEP_PAGE_MID: begin
        result.action   = ACT_ADDRESS;
        result.bus_byte = cur.page[15:8];
      end
      STEP_PAGE_HI: begin
        result.action   = ACT_ADDRESS;
        result.bus_byte = cur.page[23:16];
      end
      STEP_CMD_CONFIRM: begin
        result.action   = ACT_COMMAND;
        result.bus_byte = CMD_READ_CONFIRM;
      end
      default: begin
        result.action   = ACT_DONE;
        result.bus_byte = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= STEP_DONE;
    end else if (load) begin
      busy <= pop_valid;
      if (pop_valid) begin
        step <= first_step(job);
      end
    end else if (fire) begin
      step <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load && pop_valid) begin
      cur <= job;
    end
  end

endmodule

FILE: hdl/nprb_checker.sv
// Port-level checks for the NAND page read top level, bound to it.
module nprb_checker import nprb_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      item_valid,
  input logic      item_ready,
  input in_item_t  item,
  input logic      result_valid,
  input logic      result_ready,
  input out_item_t result
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("Stalled result item changed.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("Result item present right after reset.");

  a_select_then_setup: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && result.action == ACT_SELECT |=>
      result_valid && result.action == ACT_COMMAND && result.bus_byte == CMD_READ_SETUP)
    else $error("Select was not followed by the read setup command.");

  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last |->
      result.action == ACT_STROBE || result.action == ACT_DONE ||
      (result.action == ACT_COMMAND && result.bus_byte == CMD_READ_CONFIRM))
    else $error("Last flag on an action that cannot end an item.");

  a_index_only_on_deliver: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.action != ACT_DELIVER |-> result.buffer_index == '0)
    else $error("Buffer index set on a non-delivery action.");

endmodule

bind nand_page_read_bad_block_skip_top nprb_checker u_nprb_checker (.*);
